// ----- sv/pfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

    localparam int VALUE_W = 32;
    localparam int MAG_W   = 31;  // positive values only reach the factoring loop
    localparam int COUNT_W = 5;
    localparam int DIV_W   = 16;  // trial divisors never pass 46341
    localparam int SQ_W    = 32;
    localparam int STEP_W  = 5;   // divider bit counter

    typedef struct packed {
        logic signed [VALUE_W-1:0] first_value;
        logic signed [VALUE_W-1:0] second_value;
    } pfc_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] first_count;
        logic [COUNT_W-1:0] second_count;
        logic               first_ranks_before;
    } pfc_out_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } pfc_div_status_t;

    typedef enum logic [2:0] {
        OM_IDLE,
        OM_CHECK,
        OM_DIV,
        OM_WAIT,
        OM_DONE
    } pfc_om_state_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_FIRST,
        TOP_LAUNCH,
        TOP_SECOND
    } pfc_top_state_t;

endpackage

`default_nettype wire

// ----- sv/pfc_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pfc_divider (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [pfc_pkg::MAG_W-1:0] dividend,
    input  wire logic [pfc_pkg::DIV_W-1:0] divisor,
    output pfc_pkg::pfc_div_status_t     status
);
    import pfc_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

    logic               active_reg, active_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [MAG_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   dvs_reg, dvs_next;

    logic [DIV_W:0]     shifted;
    logic [DIV_W+1:0]   diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        shifted     = {rem_reg, quo_reg[MAG_W-1]};
        diff        = {1'b0, shifted} - {2'b00, dvs_reg};
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        if (start)
        begin
            active_next = 1'b1;
            step_next   = '0;
            quo_next    = dividend;
            rem_next    = '0;
            dvs_next    = divisor;
        end
        else if (active_reg)
        begin
            // borrow clear: partial remainder covers the divisor
            if (!diff[DIV_W+1])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    assign status.done = done_reg;
    assign status.quot = quo_reg;
    assign status.rem  = rem_reg;

endmodule

`default_nettype wire

// ----- sv/pfc_omega.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Counts prime factors of one value by trial division on its own divider.
module pfc_omega (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [pfc_pkg::VALUE_W-1:0] value,
    output logic                             done,
    output logic [pfc_pkg::COUNT_W-1:0]      count
);
    import pfc_pkg::*;

    pfc_om_state_t      state_reg, state_next;
    logic [MAG_W-1:0]   n_reg, n_next;
    logic [DIV_W-1:0]   d_reg, d_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               div_start;
    pfc_div_status_t    div_status;

    pfc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= OM_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        count_reg <= count_next;
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        count_next = count_reg;
        div_start  = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            OM_IDLE:
            begin
                if (start)
                begin
                    count_next = '0;
                    n_next     = value[MAG_W-1:0];
                    d_next     = DIV_W'(2);
                    sq_next    = SQ_W'(4);
                    // zero, one and negatives have no factors
                    if (value <= VALUE_W'(signed'(1)))
                        state_next = OM_DONE;
                    else
                        state_next = OM_CHECK;
                end
            end
            OM_CHECK:
            begin
                if (sq_reg > {1'b0, n_reg})
                begin
                    // leftover cofactor above one is a prime
                    if (n_reg > MAG_W'(1))
                        count_next = count_reg + COUNT_W'(1);
                    state_next = OM_DONE;
                end
                else
                    state_next = OM_DIV;
            end
            OM_DIV:
            begin
                div_start  = 1'b1;
                state_next = OM_WAIT;
            end
            OM_WAIT:
            begin
                if (div_status.done)
                begin
                    if (div_status.rem == '0)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                        n_next     = div_status.quot;
                        state_next = OM_DIV;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + SQ_W'({d_reg, 1'b1});
                        d_next     = d_reg + DIV_W'(1);
                        state_next = OM_CHECK;
                    end
                end
            end
            OM_DONE:
            begin
                done       = 1'b1;
                state_next = OM_IDLE;
            end
            default:
                state_next = OM_IDLE;
        endcase
    end

    assign count = count_reg;

endmodule

`default_nettype wire

// ----- sv/prime_factor_count_compare.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ranks two signed 32-bit words by prime factor count with multiplicity.
// Pulse start while busy is low; the word is taken at that edge and busy
// stays high until the result goes out. The two values are factored one
// after the other on a single trial-division unit: each trial divisor runs
// a bound check, a launch, 31 restoring division steps and a done, and
// every factor found repeats the division. Trial divisors run up to the
// square root of what is left; values at most 1 skip trial division. The
// second value is launched from its own state after the first is done. The
// result sits on result for one cycle with done high and cannot be held
// off; the next word may start in that same cycle.
module prime_factor_count_compare (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire pfc_pkg::pfc_in_t operands,
    output logic                  busy,
    output logic                  done,
    output pfc_pkg::pfc_out_t     result
);
    import pfc_pkg::*;

    pfc_top_state_t            state_reg, state_next;
    logic signed [VALUE_W-1:0] a_reg, a_next;
    logic signed [VALUE_W-1:0] b_reg, b_next;
    logic [COUNT_W-1:0]        ca_reg, ca_next;
    pfc_out_t                  result_reg, result_next;
    logic                      done_reg, done_next;

    logic                      om_start;
    logic signed [VALUE_W-1:0] om_value;
    logic                      om_done;
    logic [COUNT_W-1:0]        om_count;

    pfc_omega u_omega (
        .clk   (clk),
        .rst_n (rst_n),
        .start (om_start),
        .value (om_value),
        .done  (om_done),
        .count (om_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TOP_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        ca_reg     <= ca_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        ca_next     = ca_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        om_start    = 1'b0;
        om_value    = a_reg;
        unique case (state_reg)
            TOP_IDLE:
            begin
                if (start)
                begin
                    a_next     = operands.first_value;
                    b_next     = operands.second_value;
                    om_start   = 1'b1;
                    om_value   = operands.first_value;
                    state_next = TOP_FIRST;
                end
            end
            TOP_FIRST:
            begin
                if (om_done)
                begin
                    ca_next    = om_count;
                    state_next = TOP_LAUNCH;
                end
            end
            TOP_LAUNCH:
            begin
                // factoring unit is back in idle here
                om_start   = 1'b1;
                om_value   = b_reg;
                state_next = TOP_SECOND;
            end
            TOP_SECOND:
            begin
                om_value = b_reg;
                if (om_done)
                begin
                    result_next.first_count  = ca_reg;
                    result_next.second_count = om_count;
                    if (ca_reg == om_count)
                        result_next.first_ranks_before = (a_reg > b_reg);
                    else
                        result_next.first_ranks_before = (ca_reg > om_count);
                    done_next  = 1'b1;
                    state_next = TOP_IDLE;
                end
            end
            default:
                state_next = TOP_IDLE;
        endcase
    end

    assign busy   = (state_reg != TOP_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_prime_factor_count_compare.sv -----
`timescale 1ns / 1ps

module tb_prime_factor_count_compare;
    import pfc_pkg::*;

    // The one pair holding 2^31-1 costs the most run time of any pair.
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int TAIL_CYCLES = 50;
    localparam int RANDOM_PAIRS = 80;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    pfc_in_t  operands = '0;
    logic     busy;
    logic     done;
    pfc_out_t result;

    pfc_in_t  pending_pairs[$];
    pfc_out_t expected_ranks[$];
    int       idle_left = 0;
    int       pairs_total = 0;
    int       pairs_accepted = 0;
    int       ranks_checked = 0;
    int       ranks_flagged = 0;
    int       mismatches = 0;
    int       cycle_count = 0;

    prime_factor_count_compare u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operands (operands),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Prime factors with multiplicity by trial division up to the square root.
    function automatic logic [COUNT_W-1:0] big_omega(input int value);
        longint unsigned n;
        longint unsigned d;
        int              cnt;
        cnt = 0;
        if (value <= 1)
            return '0;
        n = longint'(value);
        d = 2;
        while (d * d <= n)
        begin
            while (n % d == 0)
            begin
                cnt++;
                n = n / d;
            end
            d++;
        end
        if (n > 1)
            cnt++;
        return cnt[COUNT_W-1:0];
    endfunction

    function automatic pfc_out_t rank_pair(input pfc_in_t pair);
        pfc_out_t r;
        int       a;
        int       b;
        a = pair.first_value;
        b = pair.second_value;
        r.first_count  = big_omega(a);
        r.second_count = big_omega(b);
        if (r.first_count == r.second_count)
            r.first_ranks_before = (a > b);
        else
            r.first_ranks_before = (r.first_count > r.second_count);
        return r;
    endfunction

    // Products of small primes: reach the top bits yet factor quickly.
    function automatic int smooth_value();
        longint p;
        int     primes[6];
        int     k;
        primes = '{2, 3, 5, 7, 11, 13};
        p = 1;
        repeat ($urandom_range(1, 40))
        begin
            k = primes[$urandom_range(0, 5)];
            if (p * k <= 64'h7fff_ffff)
                p = p * k;
        end
        return int'(p);
    endfunction

    // Mostly small magnitudes so that trial division stays short.
    function automatic int pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, 31'($urandom)};
            1: return int'($urandom_range(0, 1));
            2, 3: return smooth_value();
            4: return int'(32'd1 << $urandom_range(0, 30));
            5: return int'($urandom_range(2, 65535));
            default: return int'($urandom_range(2, 1023));
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 2000);
    endfunction

    task automatic add_pair(input int a, input int b);
        pfc_in_t pair;
        pair.first_value  = a;
        pair.second_value = b;
        pending_pairs = {pending_pairs, pair};
    endtask

    // Driver: one word per accepted start; noise on operands while idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            operands  <= '0;
            idle_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_ranks = {expected_ranks, rank_pair(operands)};
                pairs_accepted++;
            end
            if (start && busy)
            begin
                // hold the word until the block takes it
            end
            else if (idle_left > 0)
            begin
                start     <= 1'b0;
                operands  <= {$urandom, $urandom};
                idle_left <= idle_left - 1;
            end
            else if (pending_pairs.size() > 0)
            begin
                start     <= 1'b1;
                operands  <= pending_pairs.pop_front();
                idle_left <= pick_gap();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: a result is valid only in the cycle that done is high.
    always @(posedge clk)
    begin
        pfc_out_t want;
        if (rst_n && done)
        begin
            if (expected_ranks.size() == 0)
            begin
                $error("result with no word pending: %0d %0d %0d", result.first_count,
                       result.second_count, result.first_ranks_before);
                mismatches++;
            end
            else
            begin
                want = expected_ranks.pop_front();
                ranks_checked++;
                if (want.first_ranks_before)
                    ranks_flagged++;
                if (result.first_count !== want.first_count)
                begin
                    $error("first_count: expected %0d, got %0d",
                           want.first_count, result.first_count);
                    mismatches++;
                end
                if (result.second_count !== want.second_count)
                begin
                    $error("second_count: expected %0d, got %0d",
                           want.second_count, result.second_count);
                    mismatches++;
                end
                if (result.first_ranks_before !== want.first_ranks_before)
                begin
                    $error("first_ranks_before: expected %0d, got %0d",
                           want.first_ranks_before, result.first_ranks_before);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_ranks.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int a;
        int b;

        // zero, one, negatives and the field extremes
        add_pair(0, 0);
        add_pair(1, 1);
        add_pair(1, 0);
        add_pair(-5, 0);
        add_pair(0, -5);
        add_pair(-1, 2);
        add_pair(-2147483648, -2147483648);
        add_pair(2147483647, -2147483648);
        add_pair(-2147483648, 2147483646);
        // largest count, and equal values
        add_pair(1073741824, 1073741824);
        add_pair(1073741824, 2147483646);
        add_pair(536870912, 1073741823);
        // count decides, then value decides on a tie
        add_pair(7, 4);
        add_pair(4, 7);
        add_pair(2, 3);
        add_pair(3, 2);
        add_pair(12, 18);
        add_pair(18, 12);
        // squares of primes hit the divisor-squared bound exactly, then a large prime
        add_pair(49, 35);
        add_pair(9409, 65521);
        add_pair(65521, 65521);

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            a = pick_value();
            b = ($urandom_range(0, 99) < 15) ? a : pick_value();
            add_pair(a, b);
        end
        pairs_total = pending_pairs.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pairs_accepted != pairs_total || expected_ranks.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d word pairs ranked (zero, negative, extreme, tied and random values),",
                 ranks_checked);
        $display("%0d with first ranking before, in %0d cycles", ranks_flagged, cycle_count);
        if (mismatches == 0 && expected_ranks.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
sv/pfc_pkg.sv
sv/pfc_divider.sv
sv/pfc_omega.sv
sv/prime_factor_count_compare.sv
tb/sv/tb_prime_factor_count_compare.sv
